### hdl/lkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, codes and the types that pass between the controller and
// the chain of storage cells.
// ----------------------------------------------------------------------------
package lkc_pkg;

   localparam int LKC_DEPTH   = 16;
   localparam int LKC_KEY_W   = 32;
   localparam int LKC_VALUE_W = 32;
   localparam int LKC_LIMIT_W = 5;

   localparam logic [LKC_LIMIT_W-1:0] LKC_LIMIT_RESET = 5'd16;

   localparam logic LKC_ACTION_GET = 1'b0;
   localparam logic LKC_ACTION_SET = 1'b1;

   localparam logic [LKC_VALUE_W-1:0] LKC_MISS_VALUE = '1;
   localparam logic [LKC_VALUE_W-1:0] LKC_SET_VALUE  = '0;

   // one hop of the sweep between neighboring cells
   typedef struct packed {
      logic                   tok;
      logic                   done;
      logic [LKC_KEY_W-1:0]   key;
      logic [LKC_VALUE_W-1:0] value;
   } lkc_link_type;

   // how a sweep ends: at the matching cell, at the last valid cell, or at
   // the first free cell
   typedef struct packed {
      logic hit;
      logic evict;
   } lkc_mode_type;

endpackage
`default_nettype wire

### hdl/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement,
// built as a chain of entry cells kept in recency order.
//
// Request: raise start with req_action (0 get, 1 set), req_key and
// req_write_value; the transfer happens at a clock edge with busy low.
// Response: rsp_strobe is high for one cycle with rsp_hit, rsp_read_value
// and rsp_evicted. There is no back-pressure; the receiver must take it.
// Sequence: a get that misses responds from the compare state; every
// other request sends a token that walks the cell chain one cell a
// cycle, and responds once the token leaves the last cell. busy drops in
// the response cycle, so the next request may transfer at the edge that
// takes the response.
// Capacity: csr_write_enable writes csr_write_data into the capacity limit;
// 0 acts as 1 and values above DEPTH act as DEPTH. Write only while idle.
// Reset: empties the store at once and sets the limit to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int DEPTH = lkc_pkg::LKC_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_action,
   input  wire logic signed [lkc_pkg::LKC_KEY_W-1:0]   req_key,
   input  wire logic signed [lkc_pkg::LKC_VALUE_W-1:0] req_write_value,
   output logic                                        rsp_strobe,
   output logic                                        rsp_hit,
   output logic signed [lkc_pkg::LKC_VALUE_W-1:0]      rsp_read_value,
   output logic                                        rsp_evicted,
   input  wire logic                                   csr_write_enable,
   input  wire logic [lkc_pkg::LKC_LIMIT_W-1:0]        csr_write_data
);
   import lkc_pkg::*;

   lkc_link_type           links [0:DEPTH];
   logic [DEPTH-1:0]       valid_vec;
   logic [DEPTH-1:0]       match_vec;
   logic                   load;
   lkc_mode_type           mode;
   logic                   fix_en;
   logic [LKC_VALUE_W-1:0] fix_value;
   logic [LKC_VALUE_W-1:0] read_value;

   lkc_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .match_vec        (match_vec),
      .link_last        (links[DEPTH]),
      .load             (load),
      .mode             (mode),
      .link_first       (links[0]),
      .fix_en           (fix_en),
      .fix_value        (fix_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (read_value),
      .rsp_evicted      (rsp_evicted)
   );

   assign rsp_read_value = read_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic nv;
      logic fe;
      if (i == DEPTH - 1) begin : g_last
         assign nv = 1'b0;
      end else begin : g_mid
         assign nv = valid_vec[i+1];
      end
      if (i == 0) begin : g_front
         assign fe = fix_en;
      end else begin : g_rest
         assign fe = 1'b0;
      end

      lkc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .req_key    (req_key),
         .mode       (mode),
         .link_in    (links[i]),
         .link_out   (links[i+1]),
         .next_valid (nv),
         .fix_en     (fe),
         .fix_value  (fix_value),
         .valid      (valid_vec[i]),
         .match      (match_vec[i])
      );
   end

endmodule
`default_nettype wire

### hdl/lkc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache storage cell
// Holds one entry at one recency position. Compares its key on a lookup and
// swaps its entry with the one handed in by its neighbor during a sweep.
// ----------------------------------------------------------------------------
module lkc_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire logic [lkc_pkg::LKC_KEY_W-1:0]  req_key,
   input  wire lkc_pkg::lkc_mode_type          mode,
   input  wire lkc_pkg::lkc_link_type          link_in,
   output lkc_pkg::lkc_link_type               link_out,
   input  wire logic                           next_valid,
   input  wire logic                           fix_en,
   input  wire logic [lkc_pkg::LKC_VALUE_W-1:0] fix_value,
   output logic                                valid,
   output logic                                match
);
   import lkc_pkg::*;

   logic                   valid_ff, valid_in;
   logic [LKC_KEY_W-1:0]   key_ff, key_in;
   logic [LKC_VALUE_W-1:0] value_ff, value_in;
   logic                   match_ff, match_in;
   lkc_link_type           link_ff, link_in_next;
   logic                   take;
   logic                   stop;

   always_comb begin
      take = link_in.tok & ~link_in.done;
      if (mode.hit) begin
         stop = match_ff;
      end else if (mode.evict) begin
         stop = valid_ff & ~next_valid;
      end else begin
         stop = ~valid_ff;
      end

      valid_in = take ? 1'b1 : valid_ff;
      key_in   = take ? link_in.key : key_ff;
      if (take) begin
         value_in = link_in.value;
      end else if (fix_en) begin
         value_in = fix_value;
      end else begin
         value_in = value_ff;
      end

      match_in = load ? (valid_ff && (key_ff == req_key)) : match_ff;

      link_in_next.tok   = link_in.tok;
      link_in_next.done  = link_in.done | (take & stop);
      link_in_next.key   = take ? key_ff : link_in.key;
      link_in_next.value = take ? value_ff : link_in.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         match_ff    <= 1'b0;
         link_ff.tok <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         link_ff  <= link_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign link_out = link_ff;
   assign valid    = valid_ff;
   assign match    = match_ff;

endmodule
`default_nettype wire

### hdl/lkc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences lookup, sweep and response, keeps the fill count and the
// capacity register.
// ----------------------------------------------------------------------------
module lkc_ctrl #(
   parameter int DEPTH = lkc_pkg::LKC_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_action,
   input  wire logic [lkc_pkg::LKC_KEY_W-1:0]    req_key,
   input  wire logic [lkc_pkg::LKC_VALUE_W-1:0]  req_write_value,
   input  wire logic                             csr_write_enable,
   input  wire logic [lkc_pkg::LKC_LIMIT_W-1:0]  csr_write_data,
   input  wire logic [DEPTH-1:0]                 match_vec,
   input  wire lkc_pkg::lkc_link_type            link_last,
   output logic                                  load,
   output lkc_pkg::lkc_mode_type                 mode,
   output lkc_pkg::lkc_link_type                 link_first,
   output logic                                  fix_en,
   output logic [lkc_pkg::LKC_VALUE_W-1:0]       fix_value,
   output logic                                  rsp_strobe,
   output logic                                  rsp_hit,
   output logic [lkc_pkg::LKC_VALUE_W-1:0]       rsp_read_value,
   output logic                                  rsp_evicted
);
   import lkc_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int EXT_W  = (FILL_W > LKC_LIMIT_W) ? FILL_W : LKC_LIMIT_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   op_action_ff, op_action_in;
   logic [LKC_KEY_W-1:0]   op_key_ff, op_key_in;
   logic [LKC_VALUE_W-1:0] op_value_ff, op_value_in;
   logic [LKC_LIMIT_W-1:0] limit_ff, limit_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   lkc_mode_type           mode_ff, mode_in;
   lkc_link_type           link_ff, link_in;
   logic                   strobe_ff, strobe_in;
   logic                   hit_ff, hit_in;
   logic [LKC_VALUE_W-1:0] read_ff, read_in;
   logic                   evicted_ff, evicted_in;

   logic                   accept;
   logic                   any_match;
   logic [EXT_W-1:0]       lim_ext;
   logic [EXT_W-1:0]       eff_lim;
   logic [EXT_W-1:0]       fill_ext;

   always_comb begin
      accept    = start & (state_ff == ST_IDLE);
      any_match = |match_vec;
      lim_ext   = EXT_W'(limit_ff);
      fill_ext  = EXT_W'(fill_ff);
      if (lim_ext == '0) begin
         eff_lim = EXT_W'(1);
      end else if (lim_ext > EXT_W'(DEPTH)) begin
         eff_lim = EXT_W'(DEPTH);
      end else begin
         eff_lim = lim_ext;
      end

      state_in     = state_ff;
      op_action_in = op_action_ff;
      op_key_in    = op_key_ff;
      op_value_in  = op_value_ff;
      limit_in     = csr_write_enable ? csr_write_data : limit_ff;
      fill_in      = fill_ff;
      mode_in      = mode_ff;
      link_in      = link_ff;
      link_in.tok  = 1'b0;
      strobe_in    = 1'b0;
      hit_in       = hit_ff;
      read_in      = read_ff;
      evicted_in   = evicted_ff;
      fix_en       = 1'b0;
      fix_value    = link_last.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_action_in = req_action;
               op_key_in    = req_key;
               op_value_in  = req_write_value;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            mode_in.hit   = any_match;
            mode_in.evict = ~any_match & (fill_ext >= eff_lim);
            if ((op_action_ff == LKC_ACTION_GET) && !any_match) begin
               strobe_in  = 1'b1;
               hit_in     = 1'b0;
               read_in    = LKC_MISS_VALUE;
               evicted_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               link_in.tok   = 1'b1;
               link_in.done  = 1'b0;
               link_in.key   = op_key_ff;
               link_in.value = op_value_ff;
               state_in      = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (link_last.tok) begin
               strobe_in = 1'b1;
               hit_in    = mode_ff.hit;
               if (op_action_ff == LKC_ACTION_GET) begin
                  read_in    = link_last.value;
                  evicted_in = 1'b0;
                  fix_en     = 1'b1;
               end else begin
                  read_in    = LKC_SET_VALUE;
                  evicted_in = mode_ff.evict;
                  if (!mode_ff.hit && !mode_ff.evict) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         limit_ff    <= LKC_LIMIT_RESET;
         fill_ff     <= '0;
         mode_ff     <= '0;
         link_ff.tok <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         fill_ff   <= fill_in;
         mode_ff   <= mode_in;
         link_ff   <= link_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_action_ff <= op_action_in;
      op_key_ff    <= op_key_in;
      op_value_ff  <= op_value_in;
      hit_ff       <= hit_in;
      read_ff      <= read_in;
      evicted_ff   <= evicted_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign load           = accept;
   assign mode           = mode_ff;
   assign link_first     = link_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = read_ff;
   assign rsp_evicted    = evicted_ff;

endmodule
`default_nettype wire

### hdl/lkc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache port checker
// Checks request and response timing and result consistency at the top
// level ports.
// ----------------------------------------------------------------------------
module lkc_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   start,
   input wire logic                                   busy,
   input wire logic                                   rsp_strobe,
   input wire logic                                   rsp_hit,
   input wire logic signed [lkc_pkg::LKC_VALUE_W-1:0] rsp_read_value,
   input wire logic                                   rsp_evicted
);
   import lkc_pkg::*;

   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response issued while busy");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   a_evict_is_set_miss : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |->
         (!rsp_hit && (rsp_read_value == LKC_SET_VALUE)))
      else $error("eviction reported on a hit or a get");

   a_miss_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |->
         ((rsp_read_value == LKC_MISS_VALUE) || (rsp_read_value == LKC_SET_VALUE)))
      else $error("miss returned an unexpected value");

endmodule

bind lru_key_value_cache lkc_checker u_lkc_checker (.*);
`default_nettype wire
